### rtl/aslbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aslbc_pkg
// Shared widths, defaults and request/response types of the any-of-set
// LRU block cache tag store.
// ----------------------------------------------------------------------------
package aslbc_pkg;

   localparam int BLOCK_W       = 24;
   localparam int SLOT_OUT_W    = 4;
   localparam int SLOTS_DEFAULT = 16;

   typedef struct packed {
      logic [BLOCK_W-1:0] candidate_block;
      logic               last_candidate;
   } req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]    chosen_block;
      logic [SLOT_OUT_W-1:0] chosen_slot;
      logic                  hit;
      logic                  evicted_valid;
      logic [BLOCK_W-1:0]    evicted_block;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/aslbc_tag_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aslbc_tag_store
// Slot tags, valid bits and recency ranks. Parallel tag match, oldest-slot
// lookup, and touch/fill update of one slot per cycle.
// ----------------------------------------------------------------------------
module aslbc_tag_store #(
   parameter int SLOTS = aslbc_pkg::SLOTS_DEFAULT,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [aslbc_pkg::BLOCK_W-1:0] lookup_block,
   output logic                              match_any,
   output logic [SW-1:0]                     match_slot,
   output logic [SW-1:0]                     oldest_slot,
   output logic                              oldest_valid,
   output logic [aslbc_pkg::BLOCK_W-1:0]     oldest_tag,
   input  wire logic                         touch_en,
   input  wire logic [SW-1:0]                touch_slot,
   input  wire logic                         fill_en,
   input  wire logic [aslbc_pkg::BLOCK_W-1:0] fill_tag
);

   logic [aslbc_pkg::BLOCK_W-1:0] tag_ff [SLOTS];
   logic [SLOTS-1:0]              valid_ff;
   logic [SW-1:0]                 rank_ff [SLOTS];
   logic [SW-1:0]                 touch_rank;

   always_comb begin
      match_any    = 1'b0;
      match_slot   = '0;
      oldest_slot  = '0;
      oldest_valid = 1'b0;
      oldest_tag   = '0;
      touch_rank   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (valid_ff[i] && (tag_ff[i] == lookup_block)) begin
            match_any  = 1'b1;
            match_slot = SW'(i);
         end
         if (rank_ff[i] == SW'(SLOTS - 1)) begin
            oldest_slot  = SW'(i);
            oldest_valid = oldest_valid | valid_ff[i];
            oldest_tag   = oldest_tag | tag_ff[i];
         end
         if (SW'(i) == touch_slot) begin
            touch_rank = touch_rank | rank_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            rank_ff[i] <= SW'(i);
         end
      end else if (touch_en) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (SW'(i) == touch_slot) begin
               rank_ff[i] <= '0;
               if (fill_en) begin
                  valid_ff[i] <= 1'b1;
               end
            end else if (rank_ff[i] < touch_rank) begin
               rank_ff[i] <= rank_ff[i] + SW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (touch_en && fill_en) begin
         tag_ff[touch_slot] <= fill_tag;
      end
   end

endmodule
`default_nettype wire

### rtl/any_of_set_lru_block_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// any_of_set_lru_block_cache
// Fully associative LRU tag store answering any-of-set block requests.
// ----------------------------------------------------------------------------
// Candidates of a request arrive one per cycle, the final one marked last.
// Each candidate is registered, matched against all slots in parallel in the
// following cycle, and folded into a running smallest-hit and smallest-
// candidate. Once the response register is free, the last candidate produces
// one registered response: a hit on the smallest resident candidate, or a
// miss that maps the smallest candidate into the least recently used slot
// and reports the displaced block. A new candidate is taken every cycle;
// only a waiting response that is not taken holds back a last candidate.
// After reset no block is resident and unused slots are oldest, highest slot first.
// ----------------------------------------------------------------------------
module any_of_set_lru_block_cache #(
   parameter int SLOTS = aslbc_pkg::SLOTS_DEFAULT,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire aslbc_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output aslbc_pkg::rsp_type      rsp_data
);

   aslbc_pkg::req_type in_ff;
   logic               in_valid_ff;
   logic               open_ff;
   logic               have_ff;
   logic [aslbc_pkg::BLOCK_W-1:0] best_block_ff;
   logic [SW-1:0]                 best_slot_ff;
   logic [aslbc_pkg::BLOCK_W-1:0] small_ff;
   logic               rsp_valid_ff;
   aslbc_pkg::rsp_type rsp_data_ff;
   aslbc_pkg::rsp_type rsp_data_in;

   logic                          match_any;
   logic [SW-1:0]                 match_slot;
   logic [SW-1:0]                 oldest_slot;
   logic                          oldest_valid;
   logic [aslbc_pkg::BLOCK_W-1:0] oldest_tag;

   logic                          out_free;
   logic                          proc_go;
   logic                          last_go;
   logic [aslbc_pkg::BLOCK_W-1:0] cand;
   logic [aslbc_pkg::BLOCK_W-1:0] small_in;
   logic                          base_have;
   logic                          take;
   logic                          have_in;
   logic [aslbc_pkg::BLOCK_W-1:0] best_block_in;
   logic [SW-1:0]                 best_slot_in;
   logic [SW-1:0]                 chosen_slot;

   assign cand      = in_ff.candidate_block;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc_go   = in_valid_ff && (!in_ff.last_candidate || out_free);
   assign last_go   = proc_go && in_ff.last_candidate;
   assign req_ready = !in_valid_ff || proc_go;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   aslbc_tag_store #(
      .SLOTS(SLOTS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .lookup_block(cand),
      .match_any   (match_any),
      .match_slot  (match_slot),
      .oldest_slot (oldest_slot),
      .oldest_valid(oldest_valid),
      .oldest_tag  (oldest_tag),
      .touch_en    (last_go),
      .touch_slot  (chosen_slot),
      .fill_en     (!have_in),
      .fill_tag    (small_in)
   );

   always_comb begin
      small_in      = (open_ff && (small_ff < cand)) ? small_ff : cand;
      base_have     = open_ff && have_ff;
      take          = match_any && (!base_have || (cand < best_block_ff));
      have_in       = base_have || take;
      best_block_in = take ? cand : best_block_ff;
      best_slot_in  = take ? match_slot : best_slot_ff;
      chosen_slot   = have_in ? best_slot_in : oldest_slot;

      rsp_data_in.chosen_block  = have_in ? best_block_in : small_in;
      rsp_data_in.chosen_slot   = aslbc_pkg::SLOT_OUT_W'(chosen_slot);
      rsp_data_in.hit           = have_in;
      rsp_data_in.evicted_valid = !have_in && oldest_valid;
      rsp_data_in.evicted_block = (!have_in && oldest_valid) ? oldest_tag : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         open_ff      <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (proc_go) begin
            open_ff <= !in_ff.last_candidate;
            have_ff <= have_in && !in_ff.last_candidate;
         end
         if (last_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
      if (proc_go) begin
         best_block_ff <= best_block_in;
         best_slot_ff  <= best_slot_in;
         small_ff      <= small_in;
      end
      if (last_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.hit |-> !rsp_data_ff.evicted_valid)
      else $error("hit response reports an eviction");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_go |=> in_valid_ff && $stable(in_ff))
      else $error("stalled request register changed");

   a_last_responds: assert property (@(posedge clock) disable iff (reset)
      last_go |=> rsp_valid_ff)
      else $error("last candidate produced no response");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.evicted_valid |-> rsp_data_ff.evicted_block == '0)
      else $error("evicted block set without eviction");
`endif

endmodule
`default_nettype wire

### verif/any_of_set_lru_block_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// any_of_set_lru_block_cache_tb
// Streams candidate sets into the LRU block cache tag store under random
// pacing and backpressure. A shadow tag store with its own recency ranks
// predicts each answer, and every answer is checked field by field in order.
// ----------------------------------------------------------------------------
module any_of_set_lru_block_cache_tb;

   localparam int NUM_SLOTS   = aslbc_pkg::SLOTS_DEFAULT;
   localparam int POOL_SIZE   = 24;
   localparam int ITEM_TARGET = 1700;

   class block_cache_scoreboard;
      logic [aslbc_pkg::BLOCK_W-1:0]    slot_block[NUM_SLOTS];
      bit                               slot_used[NUM_SLOTS];
      int unsigned                      slot_age[NUM_SLOTS];
      bit                               set_open;
      bit                               set_has_hit;
      logic [aslbc_pkg::BLOCK_W-1:0]    hit_block;
      logic [aslbc_pkg::SLOT_OUT_W-1:0] hit_slot;
      logic [aslbc_pkg::BLOCK_W-1:0]    min_block;
      aslbc_pkg::rsp_type               expected_answers[$];
      int                               errors;

      function new();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_block[i] = '0;
            slot_used[i]  = 1'b0;
            slot_age[i]   = i;
         end
         set_open    = 1'b0;
         set_has_hit = 1'b0;
         hit_block   = '0;
         hit_slot    = '0;
         min_block   = '0;
         errors      = 0;
      endfunction

      function int outstanding();
         return expected_answers.size();
      endfunction

      function void note_candidate(aslbc_pkg::req_type r);
         aslbc_pkg::rsp_type answer;
         int                 slot;
         int                 oldest_age;
         slot       = 0;
         oldest_age = 0;
         answer     = '0;
         if (!set_open) begin
            set_has_hit = 1'b0;
            hit_block   = '0;
            hit_slot    = '0;
            min_block   = r.candidate_block;
         end else if (r.candidate_block < min_block) begin
            min_block = r.candidate_block;
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_used[i] && slot_block[i] == r.candidate_block &&
                (!set_has_hit || r.candidate_block < hit_block)) begin
               set_has_hit = 1'b1;
               hit_block   = r.candidate_block;
               hit_slot    = aslbc_pkg::SLOT_OUT_W'(i);
            end
         end
         if (!r.last_candidate) begin
            set_open = 1'b1;
            return;
         end
         set_open = 1'b0;
         if (set_has_hit) begin
            answer.chosen_block = hit_block;
            answer.hit          = 1'b1;
            slot                = int'(hit_slot);
         end else begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot_age[i] == NUM_SLOTS - 1) slot = i;
            answer.chosen_block = min_block;
            if (slot_used[slot]) begin
               answer.evicted_valid = 1'b1;
               answer.evicted_block = slot_block[slot];
            end
            slot_block[slot] = min_block;
            slot_used[slot]  = 1'b1;
         end
         answer.chosen_slot = aslbc_pkg::SLOT_OUT_W'(slot);
         oldest_age = slot_age[slot];
         for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_age[i] < oldest_age) slot_age[i]++;
         slot_age[slot] = 0;
         expected_answers = {expected_answers, answer};
         set_has_hit = 1'b0;
         hit_block   = '0;
         hit_slot    = '0;
         min_block   = '0;
      endfunction

      function void check_answer(aslbc_pkg::rsp_type got);
         aslbc_pkg::rsp_type want;
         if (expected_answers.size() == 0) begin
            $error("unexpected response: chosen_block %h", got.chosen_block);
            errors++;
            return;
         end
         want = expected_answers.pop_front();
         if (got.chosen_block !== want.chosen_block) begin
            $error("chosen_block: expected %h, got %h", want.chosen_block,
                   got.chosen_block);
            errors++;
         end
         if (got.chosen_slot !== want.chosen_slot) begin
            $error("chosen_slot: expected %0d, got %0d", want.chosen_slot,
                   got.chosen_slot);
            errors++;
         end
         if (got.hit !== want.hit) begin
            $error("hit: expected %b, got %b", want.hit, got.hit);
            errors++;
         end
         if (got.evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %b, got %b", want.evicted_valid,
                   got.evicted_valid);
            errors++;
         end
         if (got.evicted_block !== want.evicted_block) begin
            $error("evicted_block: expected %h, got %h", want.evicted_block,
                   got.evicted_block);
            errors++;
         end
      endfunction
   endclass

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   aslbc_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   aslbc_pkg::rsp_type rsp_data;

   block_cache_scoreboard sb = new();

   logic [aslbc_pkg::BLOCK_W-1:0] block_pool[POOL_SIZE];
   int                            items_sent   = 0;
   int                            burst_left   = 0;
   bit                            gaps_enabled = 1'b1;
   bit                            rsp_hold_req = 1'b0;

   any_of_set_lru_block_cache DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_candidate(req_data);
         if (rsp_valid && rsp_ready) sb.check_answer(rsp_data);
      end
   end

   // response side: long hold-off on request, otherwise a randomly chosen stall pattern
   initial begin
      int cycle_count;
      int stall_mode;
      cycle_count = 0;
      stall_mode  = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (80) @(negedge clock);
         end else begin
            cycle_count++;
            if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (cycle_count % 4 != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL any_of_set_lru_block_cache");
      $finish;
   end

   task automatic pace_sender();
      int gap;
      if (!gaps_enabled) return;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         req_data  <= '{candidate_block: aslbc_pkg::BLOCK_W'($urandom()),
                        last_candidate: 1'($urandom_range(0, 1))};
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_candidate(input logic [aslbc_pkg::BLOCK_W-1:0] blk,
                                 input logic last_mark);
      req_valid <= 1'b1;
      req_data  <= '{candidate_block: blk, last_candidate: last_mark};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      pace_sender();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   function automatic logic [aslbc_pkg::BLOCK_W-1:0] pick_block();
      logic [aslbc_pkg::BLOCK_W-1:0] blk;
      if ($urandom_range(0, 4) != 0) blk = block_pool[$urandom_range(0, POOL_SIZE - 1)];
      else blk = aslbc_pkg::BLOCK_W'($urandom());
      return blk;
   endfunction

   function automatic void refill_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         case ($urandom_range(0, 5))
            0: block_pool[i] = '0;
            1: block_pool[i] = '1;
            2: block_pool[i] = aslbc_pkg::BLOCK_W'($urandom_range(0, 31));
            default: block_pool[i] = aslbc_pkg::BLOCK_W'($urandom());
         endcase
      end
   endfunction

   task automatic send_random_set();
      int kind;
      int set_len;
      kind = $urandom_range(0, 9);
      if (kind < 6) set_len = $urandom_range(1, 3);
      else if (kind < 9) set_len = $urandom_range(4, 6);
      else set_len = $urandom_range(7, 12);
      for (int i = 0; i < set_len; i++) send_candidate(pick_block(), i == set_len - 1);
   endtask

   initial begin
      int set_count;
      set_count = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // misses into empty slots, then hits and ties
      send_candidate(24'h000000, 1'b1);
      send_candidate(24'hFFFFFF, 1'b1);
      send_candidate(24'hFFFFFF, 1'b0);
      send_candidate(24'h000000, 1'b1);
      send_candidate(24'h000005, 1'b0);
      send_candidate(24'h000003, 1'b0);
      send_candidate(24'h000003, 1'b1);
      send_candidate(24'h000100, 1'b0);
      send_candidate(24'h000005, 1'b0);
      send_candidate(24'hFFFFFF, 1'b1);
      // fill every slot, then force an eviction
      for (int k = 1; k <= 13; k++) send_candidate(24'h1 << (k + 9), 1'b1);
      send_candidate(24'hABCDEF, 1'b1);
      wait_drained();

      refill_pool();
      while (items_sent < ITEM_TARGET) begin
         set_count++;
         if (set_count % 100 == 0) refill_pool();
         if (set_count % 50 == 0) gaps_enabled = ($urandom_range(0, 2) != 0);
         if (set_count == 40 || set_count == 300) rsp_hold_req = 1'b1;
         if (set_count == 150 || set_count == 450) wait_drained();
         send_random_set();
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("PASS any_of_set_lru_block_cache");
      end else begin
         $display("FAIL any_of_set_lru_block_cache");
      end
      $finish;
   end

endmodule
